@@ hdl/dhlt_pkg.sv @@
`timescale 1ns / 1ps
package dhlt_pkg;

    localparam logic [39:0] TWO_PI_Q37 = 40'hC9_0FDA_A221;
    localparam logic [31:0] Q31_ONE    = 32'h8000_0000;

    localparam int SIN_STEPS  = 5;
    localparam int COS_STEPS  = 6;
    localparam int HORNER_LAT = 3;
    localparam int SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};
    localparam int COS_DIV [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

    // front (fold, x), x squared, series, final round and quadrant
    localparam int SC_LAT = 2 + COS_STEPS * HORNER_LAT + 1;

    localparam int LANE_ST_CA = 0;
    localparam int LANE_ST_SA = 1;
    localparam int LANE_CA_CT = 2;
    localparam int LANE_SA_CT = 3;
    localparam int LANE_TY    = 4;
    localparam int LANE_TZ    = 5;
    localparam int LANES      = 6;

    typedef enum logic [1:0] {
        Q_FIRST,
        Q_SECOND,
        Q_THIRD,
        Q_FOURTH
    } t_quad;

endpackage

@@ hdl/dhlt_delay.sv @@
`timescale 1ns / 1ps
module dhlt_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_d
);
    logic [WIDTH-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    assign o_d = r_pipe[DEPTH-1];
endmodule

@@ hdl/dhlt_horner.sv @@
`timescale 1ns / 1ps
module dhlt_horner #(
    parameter int K = 2
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_x2,
    input  logic [31:0] i_u,
    output logic [30:0] o_x2,
    output logic [31:0] o_u
);
    import dhlt_pkg::*;

    // floor reciprocal, quotient is exact or one low
    localparam logic [31:0] M  = 32'((64'd1 << 32) / 64'(K));
    localparam logic [31:0] KV = 32'(K);

    logic [30:0] r_p, r_x2_a;
    logic [30:0] r_q0, r_p_b, r_x2_b;
    logic [31:0] r_u;
    logic [30:0] r_x2_c;
    logic [30:0] n_p, n_q0;
    logic [31:0] n_rem, n_q, n_u;

    always_comb begin
        n_p   = 31'((63'(i_x2) * 63'(i_u)) >> 31);
        n_q0  = 31'((63'(r_p) * 63'(M)) >> 32);
        n_rem = 32'(r_p_b) - 32'(32'(r_q0) * KV);
        n_q   = 32'(r_q0) + ((n_rem >= KV) ? 32'd1 : 32'd0);
        n_u   = Q31_ONE - n_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= n_p;
            r_x2_a <= i_x2;
            r_q0   <= n_q0;
            r_p_b  <= r_p;
            r_x2_b <= r_x2_a;
            r_u    <= n_u;
            r_x2_c <= r_x2_b;
        end
    end

    assign o_x2 = r_x2_c;
    assign o_u  = r_u;
endmodule

@@ hdl/dhlt_sincos.sv @@
`timescale 1ns / 1ps
module dhlt_sincos #(
    parameter int ANGLE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [ANGLE_BITS-1:0]         i_angle,
    output logic signed [TRIG_FRAC_BITS+1:0] o_sin,
    output logic signed [TRIG_FRAC_BITS+1:0] o_cos
);
    import dhlt_pkg::*;

    localparam int AB  = ANGLE_BITS;
    localparam int F   = TRIG_FRAC_BITS;
    localparam int W   = F + 2;
    localparam int RB  = AB - 2;
    localparam int PRW = AB + 38;
    localparam logic [AB-2:0]  QUARTER = (AB-1)'(1) << (AB - 2);
    localparam logic [RB-1:0]  EIGHTH  = RB'(1) << (AB - 3);
    localparam logic [PRW-1:0] X_HALF  = PRW'(1) << (AB + 5);
    localparam logic [62:0]    SQ_HALF = 63'(1) << 30;
    localparam logic [32:0]    T_HALF  = 33'(1) << (30 - F);
    localparam int X_DLY = SIN_STEPS * HORNER_LAT;
    localparam int T_DLY = (COS_STEPS - SIN_STEPS) * HORNER_LAT - 1;
    localparam int Q_DLY = COS_STEPS * HORNER_LAT;

    logic [1:0]  r_q_a, r_q_b;
    logic        r_fold_a, r_fold_b;
    logic [30:0] r_x_a, r_x_b, r_x2;
    logic        n_fold;
    logic [RB-1:0] n_r;
    logic [30:0] n_x;

    always_comb begin
        n_fold = i_angle[RB-1:0] > EIGHTH;
        n_r    = n_fold ? RB'(QUARTER - {1'b0, i_angle[RB-1:0]}) : i_angle[RB-1:0];
        n_x    = 31'((PRW'(n_r) * PRW'(TWO_PI_Q37) + X_HALF) >> (AB + 6));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q_a    <= i_angle[AB-1:AB-2];
            r_fold_a <= n_fold;
            r_x_a    <= n_x;
            r_q_b    <= r_q_a;
            r_fold_b <= r_fold_a;
            r_x_b    <= r_x_a;
            r_x2     <= 31'((63'(r_x_a) * 63'(r_x_a) + SQ_HALF) >> 31);
        end
    end

    // series chains
    logic [30:0] s_x2 [SIN_STEPS];
    logic [31:0] s_u  [SIN_STEPS+1];
    logic [30:0] c_x2 [COS_STEPS];
    logic [31:0] c_u  [COS_STEPS+1];

    assign s_x2[0] = r_x2;
    assign s_u[0]  = Q31_ONE;
    assign c_x2[0] = r_x2;
    assign c_u[0]  = Q31_ONE;

    for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
        if (i < SIN_STEPS - 1) begin : g_mid
            dhlt_horner #(.K(SIN_DIV[i])) u_step (
                .i_clk(i_clk), .i_en(i_en), .i_x2(s_x2[i]), .i_u(s_u[i]),
                .o_x2(s_x2[i+1]), .o_u(s_u[i+1])
            );
        end else begin : g_last
            dhlt_horner #(.K(SIN_DIV[i])) u_step (
                .i_clk(i_clk), .i_en(i_en), .i_x2(s_x2[i]), .i_u(s_u[i]),
                .o_x2(), .o_u(s_u[i+1])
            );
        end
    end

    for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
        if (i < COS_STEPS - 1) begin : g_mid
            dhlt_horner #(.K(COS_DIV[i])) u_step (
                .i_clk(i_clk), .i_en(i_en), .i_x2(c_x2[i]), .i_u(c_u[i]),
                .o_x2(c_x2[i+1]), .o_u(c_u[i+1])
            );
        end else begin : g_last
            dhlt_horner #(.K(COS_DIV[i])) u_step (
                .i_clk(i_clk), .i_en(i_en), .i_x2(c_x2[i]), .i_u(c_u[i]),
                .o_x2(), .o_u(c_u[i+1])
            );
        end
    end

    logic [30:0] x_d;
    logic [30:0] r_t;
    logic [30:0] t_d;
    logic [2:0]  qf_d;

    dhlt_delay #(.WIDTH(31), .DEPTH(X_DLY)) u_x_dly (
        .i_clk(i_clk), .i_en(i_en), .i_d(r_x_b), .o_d(x_d)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= 31'((63'(x_d) * 63'(s_u[SIN_STEPS])) >> 31);
        end
    end

    dhlt_delay #(.WIDTH(31), .DEPTH(T_DLY)) u_t_dly (
        .i_clk(i_clk), .i_en(i_en), .i_d(r_t), .o_d(t_d)
    );

    dhlt_delay #(.WIDTH(3), .DEPTH(Q_DLY)) u_q_dly (
        .i_clk(i_clk), .i_en(i_en), .i_d({r_q_b, r_fold_b}), .o_d(qf_d)
    );

    logic signed [W-1:0] n_sm, n_cm, n_s1, n_c1, n_sin, n_cos;

    always_comb begin
        n_sm = W'((33'(t_d) + T_HALF) >> (31 - F));
        n_cm = W'((33'(c_u[COS_STEPS]) + T_HALF) >> (31 - F));
        n_s1 = qf_d[0] ? n_cm : n_sm;
        n_c1 = qf_d[0] ? n_sm : n_cm;
        unique case (t_quad'(qf_d[2:1]))
            Q_FIRST: begin
                n_sin = n_s1;
                n_cos = n_c1;
            end
            Q_SECOND: begin
                n_sin = n_c1;
                n_cos = -n_s1;
            end
            Q_THIRD: begin
                n_sin = -n_s1;
                n_cos = -n_c1;
            end
            Q_FOURTH: begin
                n_sin = -n_c1;
                n_cos = n_s1;
            end
            default: begin
                n_sin = n_s1;
                n_cos = n_c1;
            end
        endcase
    end

    logic signed [W-1:0] r_sin, r_cos;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
endmodule

@@ hdl/dh_link_transform_unit.sv @@
`timescale 1ns / 1ps
// channel  direction  handshake           word
// in       to block   i_valid / o_stall   link length, twist, offset, joint angle
// out      from block o_valid / i_stall   r00..r22 less r02, tx, ty, tz
//
// one word in and one word out per cycle unless a waiting output word is held by i_stall
// latency is set by the cosine series: six steps of three stages each
// i_rst_n is synchronous and clears only the valid bits
// the whole pipeline holds while a word waits at the output under i_stall
module dh_link_transform_unit #(
    parameter int ANGLE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [31:0]               i_link_length,
    input  logic signed [ANGLE_BITS-1:0]     i_twist_angle,
    input  logic signed [31:0]               i_joint_offset,
    input  logic signed [ANGLE_BITS-1:0]     i_joint_angle,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [TRIG_FRAC_BITS+1:0] o_r00,
    output logic signed [TRIG_FRAC_BITS+1:0] o_r10,
    output logic signed [TRIG_FRAC_BITS+1:0] o_r20,
    output logic signed [TRIG_FRAC_BITS+1:0] o_r01,
    output logic signed [TRIG_FRAC_BITS+1:0] o_r11,
    output logic signed [TRIG_FRAC_BITS+1:0] o_r21,
    output logic signed [TRIG_FRAC_BITS+1:0] o_r12,
    output logic signed [TRIG_FRAC_BITS+1:0] o_r22,
    output logic signed [31:0]               o_tx,
    output logic signed [31:0]               o_ty,
    output logic signed [31:0]               o_tz
);
    import dhlt_pkg::*;

    localparam int F   = TRIG_FRAC_BITS;
    localparam int W   = F + 2;
    localparam int PW  = W + 32;
    localparam int MW  = PW + 1 - F;
    localparam int LAT = SC_LAT + 4;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (F - 1);
    localparam logic signed [W-1:0] TRIG_ONE = W'(1) << F;

    logic en;
    logic [LAT-1:0] r_vld;

    assign o_stall = r_vld[LAT-1] & i_stall;
    assign en      = ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    logic signed [W-1:0] st, ct, sa, ca;

    dhlt_sincos #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(F)) u_joint (
        .i_clk(i_clk), .i_en(en), .i_angle(i_joint_angle), .o_sin(st), .o_cos(ct)
    );

    dhlt_sincos #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(F)) u_twist (
        .i_clk(i_clk), .i_en(en), .i_angle(i_twist_angle), .o_sin(sa), .o_cos(ca)
    );

    logic [63:0] da_d;
    logic signed [31:0] d_d;

    dhlt_delay #(.WIDTH(64), .DEPTH(SC_LAT)) u_len_dly (
        .i_clk(i_clk), .i_en(en), .i_d({i_joint_offset, i_link_length}), .o_d(da_d)
    );

    assign d_d = da_d[63:32];

    // direct elements and tx ride alongside the product stages
    logic [4*W+31:0] pass_d;
    logic signed [W-1:0] n_nst, n_nsa;

    assign n_nst = -st;
    assign n_nsa = -sa;

    dhlt_delay #(.WIDTH(4*W+32), .DEPTH(3)) u_pass_dly (
        .i_clk(i_clk), .i_en(en), .i_d({ct, n_nst, n_nsa, ca, da_d[31:0]}), .o_d(pass_d)
    );

    logic signed [PW-1:0] r_prod [LANES];
    logic [PW-1:0]        r_mag  [LANES];
    logic [LANES-1:0]     r_neg, r_neg_b;
    logic [MW-1:0]        r_m    [LANES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod[LANE_ST_CA] <= st * ca;
            r_prod[LANE_ST_SA] <= st * sa;
            r_prod[LANE_CA_CT] <= ca * ct;
            r_prod[LANE_SA_CT] <= sa * ct;
            r_prod[LANE_TY]    <= sa * d_d;
            r_prod[LANE_TZ]    <= ca * d_d;
            for (int i = 0; i < LANES; i++) begin
                r_neg[i] <= r_prod[i][PW-1];
                r_mag[i] <= r_prod[i][PW-1] ? PW'(-r_prod[i]) : PW'(r_prod[i]);
                r_m[i]   <= MW'(({1'b0, r_mag[i]} + HALF) >> F);
            end
            r_neg_b <= r_neg;
        end
    end

    logic signed [MW:0] v [LANES];
    logic [31:0] n_ty, n_tz;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            // ty takes the negated twist sine
            if (r_neg_b[i] ^ (i == LANE_TY)) begin
                v[i] = -$signed({1'b0, r_m[i]});
            end else begin
                v[i] = $signed({1'b0, r_m[i]});
            end
        end
        if ((&v[LANE_TY][MW:31]) | ~(|v[LANE_TY][MW:31])) begin
            n_ty = v[LANE_TY][31:0];
        end else begin
            n_ty = v[LANE_TY][MW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if ((&v[LANE_TZ][MW:31]) | ~(|v[LANE_TZ][MW:31])) begin
            n_tz = v[LANE_TZ][31:0];
        end else begin
            n_tz = v[LANE_TZ][MW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    logic signed [W-1:0] r_r00, r_r10, r_r20, r_r01, r_r11, r_r21, r_r12, r_r22;
    logic signed [31:0]  r_tx, r_ty, r_tz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r00 <= pass_d[4*W+31:3*W+32];
            r_r01 <= pass_d[3*W+31:2*W+32];
            r_r12 <= pass_d[2*W+31:W+32];
            r_r22 <= pass_d[W+31:32];
            r_tx  <= pass_d[31:0];
            r_r10 <= v[LANE_ST_CA][W-1:0];
            r_r20 <= v[LANE_ST_SA][W-1:0];
            r_r11 <= v[LANE_CA_CT][W-1:0];
            r_r21 <= v[LANE_SA_CT][W-1:0];
            r_ty  <= n_ty;
            r_tz  <= n_tz;
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_r00   = r_r00;
    assign o_r10   = r_r10;
    assign o_r20   = r_r20;
    assign o_r01   = r_r01;
    assign o_r11   = r_r11;
    assign o_r21   = r_r21;
    assign o_r12   = r_r12;
    assign o_r22   = r_r22;
    assign o_tx    = r_tx;
    assign o_ty    = r_ty;
    assign o_tz    = r_tz;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_r22 <= TRIG_ONE && o_r22 >= -TRIG_ONE
                     && o_r00 <= TRIG_ONE && o_r00 >= -TRIG_ONE))
        else $error("cosine out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_r00 == TRIG_ONE) |-> (o_r21 == -o_r12 && o_r11 == o_r22))
        else $error("products disagree with unit joint cosine");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_r01 == '0) |-> (o_r10 == '0 && o_r20 == '0))
        else $error("products not zero at zero joint sine");
endmodule
